// File: rtl/q16fx_pkg.sv
// Shared types and codes for the Q16.16 fixed-point arithmetic unit.
`default_nettype none

package q16fx_pkg;

    localparam int DATA_W = 32;
    localparam int UNIT_W = DATA_W + 1;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [DATA_W-1:0] MIN_VALUE = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

    typedef struct packed {
        logic [UNIT_W-1:0] x;
        logic [UNIT_W-1:0] y;
        logic              sub;
    } unit_in_t;

endpackage

`default_nettype wire

// File: rtl/q16fx_addsub.sv
// Shared 33-bit adder/subtractor used for every arithmetic step.
`default_nettype none

module q16fx_addsub
    import q16fx_pkg::*;
(
    input  wire unit_in_t          uin,
    output logic [UNIT_W-1:0]      sum
);

    logic [UNIT_W-1:0] y_eff;

    assign y_eff = uin.sub ? ~uin.y : uin.y;
    assign sum   = uin.x + y_eff + {{(UNIT_W-1){1'b0}}, uin.sub};

endmodule

`default_nettype wire

// File: rtl/q16fx_core.sv
// Sequencer and working registers for add, subtract, multiply and divide.
`default_nettype none

module q16fx_core
    import q16fx_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire req_t  req,
    input  wire logic  take,
    output stat_t      stat,
    output rsp_t       rsp
);

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DATA_W - 1);
    localparam logic [DATA_W-1:0] BIT_INIT = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MAGA = 4'd3;
    localparam logic [3:0] S_MAGB = 4'd4;
    localparam logic [3:0] S_PRE  = 4'd5;
    localparam logic [3:0] S_TOP  = 4'd6;
    localparam logic [3:0] S_LOOP = 4'd7;
    localparam logic [3:0] S_RND  = 4'd8;
    localparam logic [3:0] S_INC  = 4'd9;
    localparam logic [3:0] S_SIGN = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic [DATA_W-1:0] bit_reg, bit_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [UNIT_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [1:0]        st_reg, st_next;

    unit_in_t          uin;
    logic [UNIT_W-1:0] sum;
    logic              ge;
    logic [UNIT_W-1:0] acc;
    logic [DATA_W-1:0] rem_sel;
    logic [2*DATA_W-1:0] prod;

    q16fx_addsub u_addsub (
        .uin (uin),
        .sum (sum)
    );

    // Unsigned compare result when the unit runs rem - div
    assign ge = ~sum[UNIT_W-1];

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        bit_next   = bit_reg;
        quo_next   = quo_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        uin.x      = '0;
        uin.y      = '0;
        uin.sub    = 1'b0;
        acc        = hi_reg;
        rem_sel    = rem_reg;
        prod       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = req.op;
                    a_next   = req.a;
                    b_next   = req.b;
                    hi_next  = '0;
                    lo_next  = req.b;
                    cnt_next = '0;
                    quo_next = '0;
                    bit_next = BIT_INIT;
                    st_next  = ST_OK;
                    case (req.op)
                        OP_ADD, OP_SUB: state_next = S_ADD;
                        OP_MUL:         state_next = S_MUL;
                        default:
                        begin
                            if (req.b == '0)
                            begin
                                res_next   = MIN_VALUE;
                                st_next    = ST_DIV0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MAGA;
                            end
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                uin.x      = {a_reg[DATA_W-1], a_reg};
                uin.y      = {b_reg[DATA_W-1], b_reg};
                uin.sub    = (op_reg == OP_SUB);
                res_next   = sum[DATA_W-1:0];
                state_next = S_DONE;
            end

            S_MUL:
            begin
                // Signed shift-add step; the last multiplier bit carries negative weight
                uin.x    = hi_reg;
                uin.y    = {a_reg[DATA_W-1], a_reg};
                uin.sub  = (cnt_reg == MUL_LAST);
                acc      = lo_reg[0] ? sum : hi_reg;
                hi_next  = {acc[UNIT_W-1], acc[UNIT_W-1:1]};
                lo_next  = {acc[0], lo_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                prod     = {hi_next[DATA_W-1:0], lo_next};
                if (cnt_reg == MUL_LAST)
                begin
                    res_next   = prod[FRAC_BITS +: DATA_W];
                    state_next = S_DONE;
                end
            end

            S_MAGA:
            begin
                uin.x      = '0;
                uin.y      = {1'b0, a_reg};
                uin.sub    = 1'b1;
                rem_next   = a_reg[DATA_W-1] ? sum[DATA_W-1:0] : a_reg;
                state_next = S_MAGB;
            end

            S_MAGB:
            begin
                uin.x      = '0;
                uin.y      = {1'b0, b_reg};
                uin.sub    = 1'b1;
                div_next   = b_reg[DATA_W-1] ? sum[DATA_W-1:0] : b_reg;
                state_next = S_PRE;
            end

            S_PRE:
            begin
                // Advance the divisor while it is below the dividend (div - rem borrows)
                uin.x   = {1'b0, div_reg};
                uin.y   = {1'b0, rem_reg};
                uin.sub = 1'b1;
                if (sum[UNIT_W-1])
                begin
                    div_next = {div_reg[DATA_W-2:0], 1'b0};
                    bit_next = {bit_reg[DATA_W-2:0], 1'b0};
                end
                else if (bit_reg == '0)
                begin
                    res_next   = MIN_VALUE;
                    st_next    = ST_OVF;
                    state_next = S_DONE;
                end
                else if (div_reg[DATA_W-1])
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end

            S_TOP:
            begin
                uin.x   = {1'b0, rem_reg};
                uin.y   = {1'b0, div_reg};
                uin.sub = 1'b1;
                if (ge)
                begin
                    quo_next = quo_reg | bit_reg;
                    rem_next = sum[DATA_W-1:0];
                end
                div_next   = {1'b0, div_reg[DATA_W-1:1]};
                bit_next   = {1'b0, bit_reg[DATA_W-1:1]};
                state_next = S_LOOP;
            end

            S_LOOP:
            begin
                uin.x   = {1'b0, rem_reg};
                uin.y   = {1'b0, div_reg};
                uin.sub = 1'b1;
                if ((bit_reg == '0) || (rem_reg == '0))
                begin
                    state_next = S_RND;
                end
                else
                begin
                    if (ge)
                    begin
                        quo_next = quo_reg | bit_reg;
                        rem_sel  = sum[DATA_W-1:0];
                    end
                    rem_next = {rem_sel[DATA_W-2:0], 1'b0};
                    bit_next = {1'b0, bit_reg[DATA_W-1:1]};
                end
            end

            S_RND:
            begin
                uin.x      = {1'b0, rem_reg};
                uin.y      = {1'b0, div_reg};
                uin.sub    = 1'b1;
                state_next = ge ? S_INC : S_SIGN;
            end

            S_INC:
            begin
                uin.x      = {1'b0, quo_reg};
                uin.y      = {{(UNIT_W-1){1'b0}}, 1'b1};
                uin.sub    = 1'b0;
                quo_next   = sum[DATA_W-1:0];
                state_next = S_SIGN;
            end

            S_SIGN:
            begin
                uin.x   = '0;
                uin.y   = {1'b0, quo_reg};
                uin.sub = 1'b1;
                if (a_reg[DATA_W-1] ^ b_reg[DATA_W-1])
                begin
                    if (quo_reg == MIN_VALUE)
                    begin
                        res_next = MIN_VALUE;
                        st_next  = ST_OVF;
                    end
                    else
                    begin
                        res_next = sum[DATA_W-1:0];
                    end
                end
                else
                begin
                    res_next = quo_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        bit_reg <= bit_next;
        quo_reg <= quo_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        st_reg  <= st_next;
    end

    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.done  = (state_reg == S_DONE);
    assign rsp.result = res_reg;
    assign rsp.status = st_reg;

    // Error statuses always carry the minimum value
    a_err_min: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && (st_reg != ST_OK) |-> res_reg == MIN_VALUE)
        else $error("error status without minimum result");

    // Only divide can report a nonzero status
    a_st_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && (op_reg != OP_DIV) |-> st_reg == ST_OK)
        else $error("nonzero status on non-divide operation");

    // Quotient bit stays a single bit or empty during the divide
    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRE) || (state_reg == S_TOP) || (state_reg == S_LOOP)
        |-> $onehot0(bit_reg))
        else $error("quotient bit not one-hot");

    // Partial remainder stays below twice the divisor in the main loop
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> {1'b0, rem_reg} < {div_reg, 1'b0})
        else $error("partial remainder out of range");

    // A finished result holds until the output side takes it
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && !take |=> stat.done && $stable(res_reg) && $stable(st_reg))
        else $error("finished result changed before it was taken");

endmodule

`default_nettype wire

// File: rtl/q16_16_fixed_point_alu.sv
// Top level of the signed Q16.16 fixed-point arithmetic unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  request | in        | in_valid/in_ready  | req_type, operand_a, operand_b
//  result  | out       | out_valid/out_ready| result, status
//
// Steps per item, from acceptance to the result register being loaded:
//   add/subtract takes a single adder pass, multiply one shift-add step per
//   multiplier bit, divide by zero goes straight to done, and divide runs
//   the magnitude steps for both operands, the divisor pre-shift steps, the
//   restoring steps including the top-bit step (ending early once the
//   remainder clears), a rounding check, the rounding increment when it
//   applies and the sign step; a quotient bit shifted out past the top ends
//   with overflow. Every step goes through the single shared 33-bit adder/subtractor.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// A new item is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register; the sequencer then
// holds its finished item until the output register frees up.
`default_nettype none

module q16_16_fixed_point_alu
    import q16fx_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] operand_a,
    input  wire logic signed [DATA_W-1:0] operand_b,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      result,
    output logic [1:0]                    status
);

    req_t  req;
    stat_t stat;
    rsp_t  rsp;
    logic  start;
    logic  take;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] result_reg, result_next;
    logic [1:0]        status_reg, status_next;

    // Accept a new item whenever the sequencer is idle
    assign in_ready = stat.idle;
    assign start    = in_valid && in_ready;

    assign req.op = req_type;
    assign req.a  = operand_a;
    assign req.b  = operand_b;

    q16fx_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .take  (take),
        .stat  (stat),
        .rsp   (rsp)
    );

    // Move the finished item into the output register when it is empty or draining
    assign take = stat.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            result_next    = rsp.result;
            status_next    = rsp.status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
